FILE: rtl/rah_pkg.sv
// ----------------------------------------------------------------------------
// rah_pkg
// Shared types and codes for the reference-counted handle allocator.
// ----------------------------------------------------------------------------
package rah_pkg;

    // Fixed field widths of the request and response words
    localparam int REQ_W    = 3;
    localparam int VTYPE_W  = 3;
    localparam int HANDLE_W = 10;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_COPY   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REF    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_UNREF  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_HANDLE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd4;

    // Type tags with special handling
    localparam logic [VTYPE_W-1:0] TY_CLASS    = 3'd5;
    localparam logic [VTYPE_W-1:0] TY_FUNCTION = 3'd6;

    // Classified operations passed from front to back
    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_COPY   = 3'd1;
    localparam logic [2:0] OP_REF    = 3'd2;
    localparam logic [2:0] OP_UNREF  = 3'd3;
    localparam logic [2:0] OP_LOOKUP = 3'd4;
    localparam logic [2:0] OP_REFUSE = 3'd5;
    localparam logic [2:0] OP_BAD    = 3'd6;

    // Command queue geometry
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;

    typedef struct packed {
        logic [2:0]          op;
        logic [VTYPE_W-1:0]  var_type;
        logic                make_constant;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

endpackage

FILE: rtl/rah_if.sv
// ----------------------------------------------------------------------------
// rah_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface rah_req_if;
    logic                             valid;
    logic                             ready;
    logic [rah_pkg::REQ_W-1:0]        req_type;
    logic [rah_pkg::VTYPE_W-1:0]      var_type;
    logic                             make_constant;
    logic [rah_pkg::HANDLE_W-1:0]     handle;

    modport source (output valid, req_type, var_type, make_constant, handle,
                    input ready);
    modport sink   (input valid, req_type, var_type, make_constant, handle,
                    output ready);
endinterface

interface rah_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [rah_pkg::STATUS_W-1:0]     status;
    logic [rah_pkg::HANDLE_W-1:0]     result_handle;
    logic [rah_pkg::VTYPE_W-1:0]      result_type;
    logic [rah_pkg::COUNT_W-1:0]      ref_count;
    logic                             is_constant;

    modport source (output valid, status, result_handle, result_type, ref_count,
                    is_constant, input ready);
    modport sink   (input valid, status, result_handle, result_type, ref_count,
                    is_constant, output ready);
endinterface

FILE: rtl/refcounted_handle_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_handle_allocator
// Reference-counted handle allocator with a FIFO free list.
//
//   channel   dir   handshake        word
//   i_req     in    valid / ready    req_type, var_type, make_constant, handle
//   o_rsp     out   valid / ready    status, result_handle, result_type,
//                                    ref_count, is_constant
//
// The back end reads the handle table and the free FIFO in its wait state,
// then modifies, writes back and loads the response register in execute.
// A two-entry command queue lets requests be accepted while the back end works.
// Reset needs no clearing pass: handles at or past the fresh counter read as
// not live. The back end holds in its execute cycle while a response waits.
// ----------------------------------------------------------------------------
module refcounted_handle_allocator #(
    parameter int NUM_HANDLES = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rah_req_if.sink   i_req,
    rah_rsp_if.source o_rsp
);

    logic          front_valid;
    logic          front_ready;
    rah_pkg::t_cmd front_cmd;
    logic          back_valid;
    logic          back_ready;
    rah_pkg::t_cmd back_cmd;

    rah_front #(
        .NUM_HANDLES (NUM_HANDLES)
    ) u_front (
        .i_req       (i_req),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    rah_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cmd   (front_cmd),
        .o_valid (back_valid),
        .i_ready (back_ready),
        .o_cmd   (back_cmd)
    );

    rah_back #(
        .NUM_HANDLES (NUM_HANDLES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_cmd),
        .o_rsp       (o_rsp)
    );

endmodule

FILE: rtl/rah_front.sv
// ----------------------------------------------------------------------------
// rah_front
// Accepts request words and classifies them into back-end commands:
// refused allocations, unknown requests and out-of-range handles are
// resolved here so the back end sees a single operation code.
// ----------------------------------------------------------------------------
module rah_front #(
    parameter int NUM_HANDLES = 1024
) (
    rah_req_if.sink          i_req,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output rah_pkg::t_cmd    o_cmd
);

    localparam logic [16:0] NH = 17'(NUM_HANDLES);

    logic handle_bad;

    // Handle 0 is reserved; anything at or past the table size is unknown
    assign handle_bad = (i_req.handle == '0) || (17'(i_req.handle) >= NH);

    // Decode request into an operation
    always_comb begin
        o_cmd.var_type      = i_req.var_type;
        o_cmd.make_constant = i_req.make_constant;
        o_cmd.handle        = i_req.handle;
        o_cmd.op            = rah_pkg::OP_BAD;
        unique case (i_req.req_type)
            rah_pkg::REQ_ALLOC: begin
                if (i_req.var_type >= rah_pkg::TY_FUNCTION)
                    o_cmd.op = rah_pkg::OP_REFUSE;
                else
                    o_cmd.op = rah_pkg::OP_ALLOC;
            end
            rah_pkg::REQ_COPY:   o_cmd.op = handle_bad ? rah_pkg::OP_BAD : rah_pkg::OP_COPY;
            rah_pkg::REQ_REF:    o_cmd.op = handle_bad ? rah_pkg::OP_BAD : rah_pkg::OP_REF;
            rah_pkg::REQ_UNREF:  o_cmd.op = handle_bad ? rah_pkg::OP_BAD : rah_pkg::OP_UNREF;
            rah_pkg::REQ_LOOKUP: o_cmd.op = handle_bad ? rah_pkg::OP_BAD : rah_pkg::OP_LOOKUP;
            default:             o_cmd.op = rah_pkg::OP_BAD;
        endcase
    end

    // Handshake passes straight to the command queue
    assign o_cmd_valid = i_req.valid;
    assign i_req.ready = i_cmd_ready;

endmodule

FILE: rtl/rah_cmdq.sv
// ----------------------------------------------------------------------------
// rah_cmdq
// Two-entry command queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module rah_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rah_pkg::t_cmd    i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output rah_pkg::t_cmd    o_cmd
);

    rah_pkg::t_cmd                  r_slot [rah_pkg::CMDQ_DEPTH];
    logic [rah_pkg::CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [rah_pkg::CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [rah_pkg::CMDQ_PTR_W:0]   r_count;
    logic                           push;
    logic                           pop;

    assign o_ready = (r_count != (rah_pkg::CMDQ_PTR_W+1)'(rah_pkg::CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push)
            r_slot[r_wr_ptr] <= i_cmd;
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push)
                r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)
                r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop)
                r_count <= r_count + 1'b1;
            else if (pop && !push)
                r_count <= r_count - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (rah_pkg::CMDQ_PTR_W+1)'(rah_pkg::CMDQ_DEPTH))
        else $error("cmdq: fill level past depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == (rah_pkg::CMDQ_PTR_W+1)'(rah_pkg::CMDQ_DEPTH))
        |-> r_wr_ptr == r_rd_ptr)
        else $error("cmdq: pointers disagree with fill level");

endmodule

FILE: rtl/rah_back.sv
// ----------------------------------------------------------------------------
// rah_back
// Executes commands against the per-handle table and the free FIFO.
// The wait state reads both memories; the execute state modifies, writes
// back and loads the response register, holding while a response waits.
// ----------------------------------------------------------------------------
module rah_back #(
    parameter int NUM_HANDLES = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  rah_pkg::t_cmd    i_cmd,
    rah_rsp_if.source        o_rsp
);

    localparam int HW = $clog2(NUM_HANDLES);
    localparam int CW = COUNT_WIDTH;
    localparam int EW = CW + 5;          // live, const, type[2:0], count
    localparam logic [HW:0]   NH        = (HW+1)'(NUM_HANDLES);
    localparam logic [HW-1:0] LAST      = HW'(NUM_HANDLES - 1);
    localparam logic [CW-1:0] CNT_MAX   = {CW{1'b1}};
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);

    localparam logic S_WAIT = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Memories
    logic [EW-1:0] r_ent_mem [NUM_HANDLES];
    logic [HW-1:0] r_fq_mem  [NUM_HANDLES];

    // Control and datapath registers
    logic                  r_state;
    rah_pkg::t_cmd         r_cmd;
    logic [EW-1:0]         r_ent_rd;
    logic [HW-1:0]         r_fq_rd;
    logic [HW:0]           r_next_fresh;
    logic [HW-1:0]         r_free_head;
    logic [HW-1:0]         r_free_tail;
    logic [HW:0]           r_free_count;
    logic                  r_out_valid;
    logic [rah_pkg::STATUS_W-1:0] r_status;
    logic [HW-1:0]         r_handle;
    logic [rah_pkg::VTYPE_W-1:0]  r_type;
    logic [CW-1:0]         r_count;
    logic                  r_const;

    logic                  rd_en;
    logic                  exec;
    logic                  out_free;
    logic                  e_live;
    logic                  e_cst;
    logic [2:0]            e_type;
    logic [CW-1:0]         e_cnt;
    logic [HW-1:0]         h_idx;
    logic                  live;
    logic                  have_free;
    logic                  have_fresh;
    logic [HW-1:0]         new_h;
    logic                  ent_we;
    logic [HW-1:0]         ent_waddr;
    logic [EW-1:0]         ent_wdata;
    logic                  fq_push;
    logic                  fq_pop;
    logic                  fresh_inc;
    logic [rah_pkg::STATUS_W-1:0] n_status;
    logic [HW-1:0]         n_handle;
    logic [2:0]            n_type;
    logic [CW-1:0]         n_count;
    logic                  n_const;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_cmd_ready = (r_state == S_WAIT);
    assign rd_en       = (r_state == S_WAIT) && i_cmd_valid;
    assign exec        = (r_state == S_EXEC) && out_free;

    // Read both memories when a command is taken
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_ent_rd <= r_ent_mem[HW'(i_cmd.handle)];
            r_fq_rd  <= r_fq_mem[r_free_head];
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (ent_we)
            r_ent_mem[ent_waddr] <= ent_wdata;
        if (fq_push)
            r_fq_mem[r_free_tail] <= h_idx;
    end

    // Unpack entry; handles at or past the fresh counter were never written
    assign e_live     = r_ent_rd[EW-1];
    assign e_cst      = r_ent_rd[EW-2];
    assign e_type     = r_ent_rd[EW-3:EW-5];
    assign e_cnt      = r_ent_rd[CW-1:0];
    assign h_idx      = HW'(r_cmd.handle);
    assign live       = e_live && ({1'b0, h_idx} < r_next_fresh);
    assign have_free  = (r_free_count != '0);
    assign have_fresh = (r_next_fresh < NH);
    assign new_h      = have_free ? r_fq_rd : r_next_fresh[HW-1:0];

    // Execute stage
    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = h_idx;
        ent_wdata = r_ent_rd;
        fq_push   = 1'b0;
        fq_pop    = 1'b0;
        fresh_inc = 1'b0;
        n_status  = rah_pkg::ST_NO_HANDLE;
        n_handle  = '0;
        n_type    = '0;
        n_count   = '0;
        n_const   = 1'b0;
        unique case (r_cmd.op)
            rah_pkg::OP_ALLOC, rah_pkg::OP_COPY: begin
                if (r_cmd.op == rah_pkg::OP_COPY && !live) begin
                    n_status = rah_pkg::ST_NO_HANDLE;
                end else if (r_cmd.op == rah_pkg::OP_COPY &&
                             (e_type == rah_pkg::TY_CLASS || e_type > rah_pkg::TY_FUNCTION)) begin
                    n_status = rah_pkg::ST_REFUSED;
                end else if (!have_free && !have_fresh) begin
                    n_status = rah_pkg::ST_EXHAUSTED;
                end else begin
                    // take a handle: free FIFO first, then the fresh counter
                    n_status  = rah_pkg::ST_OK;
                    n_handle  = new_h;
                    n_type    = (r_cmd.op == rah_pkg::OP_COPY) ? e_type : r_cmd.var_type;
                    n_const   = (r_cmd.op == rah_pkg::OP_ALLOC) && r_cmd.make_constant;
                    n_count   = n_const ? '0 : CNT_ONE;
                    ent_we    = exec;
                    ent_waddr = new_h;
                    ent_wdata = {1'b1, n_const, n_type, n_count};
                    fq_pop    = exec && have_free;
                    fresh_inc = exec && !have_free;
                end
            end
            rah_pkg::OP_REF: begin
                if (live) begin
                    n_status  = rah_pkg::ST_OK;
                    n_handle  = h_idx;
                    n_type    = e_type;
                    n_const   = e_cst;
                    n_count   = (!e_cst && e_cnt != CNT_MAX) ? e_cnt + 1'b1 : e_cnt;
                    ent_we    = exec;
                    ent_wdata = {1'b1, e_cst, e_type, n_count};
                    if (e_cst)
                        n_count = '0;
                end
            end
            rah_pkg::OP_UNREF: begin
                if (live) begin
                    n_handle = h_idx;
                    n_type   = e_type;
                    if (e_cst || e_cnt == CNT_MAX) begin
                        // constant or saturated: untouched
                        n_status = rah_pkg::ST_OK;
                        n_const  = e_cst;
                        n_count  = e_cst ? '0 : e_cnt;
                    end else if (e_cnt <= CNT_ONE) begin
                        // last reference: free the handle
                        n_status  = rah_pkg::ST_RELEASED;
                        ent_we    = exec;
                        ent_wdata = {1'b0, e_cst, e_type, {CW{1'b0}}};
                        fq_push   = exec;
                    end else begin
                        n_status  = rah_pkg::ST_OK;
                        n_count   = e_cnt - 1'b1;
                        ent_we    = exec;
                        ent_wdata = {1'b1, e_cst, e_type, n_count};
                    end
                end
            end
            rah_pkg::OP_LOOKUP: begin
                if (live) begin
                    n_status = rah_pkg::ST_OK;
                    n_handle = h_idx;
                    n_type   = e_type;
                    n_const  = e_cst;
                    n_count  = e_cst ? '0 : e_cnt;
                end
            end
            rah_pkg::OP_REFUSE: n_status = rah_pkg::ST_REFUSED;
            default:            n_status = rah_pkg::ST_NO_HANDLE;
        endcase
    end

    // Sequencer, allocation pointers and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_WAIT;
            r_next_fresh <= (HW+1)'(1);
            r_free_head  <= '0;
            r_free_tail  <= '0;
            r_free_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                S_WAIT:  if (i_cmd_valid) r_state <= S_EXEC;
                S_EXEC:  if (out_free)    r_state <= S_WAIT;
                default: r_state <= S_WAIT;
            endcase
            if (fresh_inc)
                r_next_fresh <= r_next_fresh + 1'b1;
            if (fq_pop)
                r_free_head <= (r_free_head == LAST) ? '0 : r_free_head + 1'b1;
            if (fq_push)
                r_free_tail <= (r_free_tail == LAST) ? '0 : r_free_tail + 1'b1;
            if (fq_push)
                r_free_count <= r_free_count + 1'b1;
            else if (fq_pop)
                r_free_count <= r_free_count - 1'b1;
            if (exec)
                r_out_valid <= 1'b1;
            else if (o_rsp.ready)
                r_out_valid <= 1'b0;
        end
    end

    // Command capture and response payload
    always_ff @(posedge i_clk) begin
        if (rd_en)
            r_cmd <= i_cmd;
        if (exec) begin
            r_status <= n_status;
            r_handle <= n_handle;
            r_type   <= n_type;
            r_count  <= n_count;
            r_const  <= n_const;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.result_handle = rah_pkg::HANDLE_W'(r_handle);
    assign o_rsp.result_type   = r_type;
    assign o_rsp.ref_count     = rah_pkg::COUNT_W'(r_count);
    assign o_rsp.is_constant   = r_const;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count < NH)
        else $error("back: free FIFO count out of range");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_fresh != '0 && r_next_fresh <= NH)
        else $error("back: fresh counter out of range");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fq_push && (fq_pop || fresh_inc)))
        else $error("back: release and allocation in one command");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_we |-> (r_state == S_EXEC && out_free))
        else $error("back: table write outside execute");

endmodule
